// ===== rtl/zc_pkg.sv =====
// Shared types, constants and the Fibonacci weight table for the Zeckendorf codec.
// No dependencies; every other file refers to this package by scoped names.
package zc_pkg;

    localparam int CODE_BITS = 64;
    localparam int VALUE_W   = 64;
    localparam int IDX_W     = $clog2(CODE_BITS);

    // Operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef logic [VALUE_W-1:0] weight_tab_t [0:CODE_BITS];

    // Input beat
    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] value;
    } req_beat_t;

    // Output beat
    typedef struct packed {
        logic [VALUE_W-1:0] result;
        logic               out_of_range;
    } rsp_beat_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             step;
        logic [IDX_W-1:0] idx;
        logic             publish;
    } dp_cmd_t;

    // Build weights: entry k holds F(k+2)
    function automatic weight_tab_t build_weights();
        weight_tab_t        tab;
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        logic [VALUE_W-1:0] nxt;
        a = VALUE_W'(1);
        b = VALUE_W'(2);
        for (int k = 0; k <= CODE_BITS; k++)
        begin
            nxt    = a + b;
            tab[k] = a;
            a      = b;
            b      = nxt;
        end
        return tab;
    endfunction

    localparam weight_tab_t WEIGHT_TAB = build_weights();

endpackage

// ===== rtl/zeckendorf_codec_top.sv =====
// Top level of the Zeckendorf codec: joins the controller and the datapath.
// Depends on zc_pkg, zc_ctrl and zc_dpath.
//
// Usage:
//   req channel: req_valid/req_stall with req (operation, value). operation
//   OP_ENCODE turns a binary value into a Fibonacci code, OP_DECODE sums the
//   weights F(k+2) of the set bits of a code.
//   rsp channel: rsp_valid/rsp_stall with rsp (result, out_of_range). An
//   encode input at or above F(66) gives result zero and out_of_range set.
//   Each request gives exactly one response beat.
//   The operands load at the accepting edge, then the shared compare-subtract
//   / add unit runs 64 steps (one code bit per cycle, top bit first), then
//   the result is published once the output register is free. The next
//   request is taken in the idle state that follows the publish.
//   req_stall is high while an item is being worked on.
//   A stalled response sits in the output register; the next request is
//   still taken and worked on, and holds before publishing until the
//   waiting beat leaves.
//   Reset (rst_n low, asynchronous) returns to idle and drops any result.
module zeckendorf_codec_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  zc_pkg::req_beat_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output zc_pkg::rsp_beat_t rsp
);

    zc_pkg::dp_cmd_t cmd;

    zc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    zc_dpath u_dpath (
        .clk (clk),
        .req (req),
        .cmd (cmd),
        .rsp (rsp)
    );

endmodule

// ===== rtl/zc_dpath.sv =====
// Datapath of the Zeckendorf codec: remainder, accumulator, one shared adder and
// the output register. Depends on zc_pkg for types and the weight table.
module zc_dpath (
    input  logic              clk,
    input  zc_pkg::req_beat_t req,
    input  zc_pkg::dp_cmd_t   cmd,
    output zc_pkg::rsp_beat_t rsp
);

    logic                       op_reg;
    logic                       oor_reg;
    logic [zc_pkg::VALUE_W-1:0] rem_reg;
    logic [zc_pkg::VALUE_W-1:0] acc_reg;
    zc_pkg::rsp_beat_t          out_reg;

    logic [zc_pkg::VALUE_W-1:0] weight;
    logic [zc_pkg::VALUE_W-1:0] add_a;
    logic [zc_pkg::VALUE_W-1:0] add_b;
    logic [zc_pkg::VALUE_W:0]   add_sum;
    logic                       fits;

    // Pick the weight of the current code bit
    assign weight = zc_pkg::WEIGHT_TAB[cmd.idx];

    // Shared adder: remainder minus weight on encode, accumulator plus weight on decode
    always_comb
    begin
        if (op_reg == zc_pkg::OP_DECODE)
        begin
            add_a = acc_reg;
            add_b = weight;
        end
        else
        begin
            add_a = rem_reg;
            add_b = ~weight;
        end
        add_sum = {1'b0, add_a} + {1'b0, add_b}
                + {{zc_pkg::VALUE_W{1'b0}}, (op_reg == zc_pkg::OP_ENCODE)};
        // carry out of the subtract means no borrow: weight <= remainder
        fits = add_sum[zc_pkg::VALUE_W];
    end

    // Hold operands, advance one code bit per step
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.operation;
            rem_reg <= req.value;
            acc_reg <= '0;
            oor_reg <= (req.operation == zc_pkg::OP_ENCODE)
                    && (req.value >= zc_pkg::WEIGHT_TAB[zc_pkg::CODE_BITS]);
        end
        else if (cmd.step)
        begin
            if (op_reg == zc_pkg::OP_DECODE)
            begin
                if (rem_reg[cmd.idx])
                    acc_reg <= add_sum[zc_pkg::VALUE_W-1:0];
            end
            else if (fits)
            begin
                rem_reg          <= add_sum[zc_pkg::VALUE_W-1:0];
                acc_reg[cmd.idx] <= 1'b1;
            end
        end
    end

    // Output register: drop the code when the encode input was out of range
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_reg.result       <= oor_reg ? '0 : acc_reg;
            out_reg.out_of_range <= oor_reg;
        end
    end

    assign rsp = out_reg;

endmodule

// ===== rtl/zc_ctrl.sv =====
// Controller of the Zeckendorf codec: state machine, bit counter and output valid.
// Depends on zc_pkg for the command struct and widths.
module zc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output zc_pkg::dp_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [zc_pkg::IDX_W-1:0] count_reg;
    logic [zc_pkg::IDX_W-1:0] count_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     accept;
    logic                     slot_free;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign slot_free = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;

    // Sequence load, steps from the top code bit down, then publish
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.idx     = count_reg;
        cmd.publish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    count_next = zc_pkg::IDX_W'(zc_pkg::CODE_BITS - 1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step   = 1'b1;
                count_next = count_reg - 1'b1;
                if (count_reg == '0)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (slot_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on publish, clear when the beat is taken
    always_comb
    begin
        if (cmd.publish)
            valid_next = 1'b1;
        else if (valid_reg && !rsp_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN)
                   && (count_reg == zc_pkg::IDX_W'(zc_pkg::CODE_BITS - 1)))
        else $error("accepted beat did not start a full run");
    a_last_step_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && count_reg == '0) |=> (state_reg == ST_WAIT))
        else $error("run did not end after the lowest code bit");
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> slot_free)
        else $error("publish overwrote an untaken result");
    a_publish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> rsp_valid && (state_reg == ST_IDLE))
        else $error("published result not presented");
`endif

endmodule

// ===== tb/sv/zeckendorf_codec_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for zeckendorf_codec_top: encode/decode beats are predicted
// by a scoreboard class and compared field by field. Depends on zc_pkg and the RTL only.
module zeckendorf_codec_top_tb;

    localparam int QUIET_LIMIT   = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 120;
    localparam int RAND_PER_PASS = 200;

    // Predicts one response per request and checks responses in order
    class zeck_scoreboard;
        logic [zc_pkg::VALUE_W-1:0] fib_w [0:zc_pkg::CODE_BITS];
        zc_pkg::rsp_beat_t          expected_q [$];
        int                         errors;

        function new();
            fib_w[0] = zc_pkg::VALUE_W'(1);
            fib_w[1] = zc_pkg::VALUE_W'(2);
            for (int k = 2; k <= zc_pkg::CODE_BITS; k++)
                fib_w[k] = fib_w[k-1] + fib_w[k-2];
            errors = 0;
        endfunction

        // Greedy encode or weighted-sum decode
        function zc_pkg::rsp_beat_t fib_convert(zc_pkg::req_beat_t rq);
            zc_pkg::rsp_beat_t          r;
            logic [zc_pkg::VALUE_W-1:0] rem;
            r   = '0;
            rem = rq.value;
            if (rq.operation == zc_pkg::OP_ENCODE)
            begin
                if (rq.value >= fib_w[zc_pkg::CODE_BITS])
                    r.out_of_range = 1'b1;
                else
                begin
                    for (int k = zc_pkg::CODE_BITS - 1; k >= 0; k--)
                    begin
                        if (fib_w[k] <= rem)
                        begin
                            r.result[k] = 1'b1;
                            rem         = rem - fib_w[k];
                        end
                    end
                end
            end
            else
            begin
                for (int k = 0; k < zc_pkg::CODE_BITS; k++)
                    if (rq.value[k])
                        r.result = r.result + fib_w[k];
            end
            return r;
        endfunction

        function void note_request(zc_pkg::req_beat_t rq);
            expected_q.push_back(fib_convert(rq));
        endfunction

        function void check_response(zc_pkg::rsp_beat_t rs);
            zc_pkg::rsp_beat_t exp_rs;
            if (expected_q.size() == 0)
            begin
                $error("response beat with nothing pending: result=%h out_of_range=%b",
                       rs.result, rs.out_of_range);
                errors++;
                return;
            end
            exp_rs = expected_q.pop_front();
            if (rs.result !== exp_rs.result)
            begin
                $error("result: expected %h, actual %h", exp_rs.result, rs.result);
                errors++;
            end
            if (rs.out_of_range !== exp_rs.out_of_range)
            begin
                $error("out_of_range: expected %b, actual %b",
                       exp_rs.out_of_range, rs.out_of_range);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    zc_pkg::req_beat_t req       = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    zc_pkg::rsp_beat_t rsp;

    int             send_idle_pct = 0;
    int             rcv_stall_pct = 0;
    logic           hold_req      = 1'b0;
    zeck_scoreboard sb;

    zeckendorf_codec_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offer one request beat, idling at random first; hold it until taken
    task automatic send_beat(input logic op, input logic [zc_pkg::VALUE_W-1:0] val);
        zc_pkg::req_beat_t beat;
        beat.operation = op;
        beat.value     = val;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        sb.note_request(beat);
    endtask

    // Random encode input: mostly in range, with Fibonacci and threshold edges
    function automatic logic [zc_pkg::VALUE_W-1:0] pick_encode_value();
        logic [zc_pkg::VALUE_W-1:0] v;
        int                         sel;
        int                         k;
        sel = $urandom_range(9);
        k   = $urandom_range(zc_pkg::CODE_BITS, 0);
        case (sel)
            6:       v = sb.fib_w[k] + zc_pkg::VALUE_W'($urandom_range(2))
                         - zc_pkg::VALUE_W'(1);
            7:       v = zc_pkg::VALUE_W'($urandom_range(200));
            8:       v = {$urandom, $urandom};
            9:       v = sb.fib_w[zc_pkg::CODE_BITS] + zc_pkg::VALUE_W'($urandom_range(4))
                         - zc_pkg::VALUE_W'(2);
            default: v = {$urandom, $urandom} % sb.fib_w[zc_pkg::CODE_BITS];
        endcase
        return v;
    endfunction

    // Random decode input: dense, sparse (no adjacent ones) or short codes
    function automatic logic [zc_pkg::VALUE_W-1:0] pick_decode_value();
        logic [zc_pkg::VALUE_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       r = r & ~(r << 1);
            1:       r = r >> $urandom_range(63);
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(1) == 0)
                send_beat(zc_pkg::OP_ENCODE, pick_encode_value());
            else
                send_beat(zc_pkg::OP_DECODE, pick_decode_value());
        end
    endtask

    // Receiver: random stall, or a long hold-off when asked
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
                rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // Check every accepted response beat
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    // Watchdog: end the run after too long without any beat moving
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: zero, small values, weight edges, threshold, code extremes
        send_idle_pct = 6;
        rcv_stall_pct = 45;
        send_beat(zc_pkg::OP_ENCODE, 64'd0);
        send_beat(zc_pkg::OP_ENCODE, 64'd1);
        send_beat(zc_pkg::OP_ENCODE, 64'd2);
        send_beat(zc_pkg::OP_ENCODE, 64'd4);
        send_beat(zc_pkg::OP_ENCODE, 64'd12);
        send_beat(zc_pkg::OP_ENCODE, sb.fib_w[zc_pkg::CODE_BITS-1]);
        send_beat(zc_pkg::OP_ENCODE, sb.fib_w[zc_pkg::CODE_BITS] - 64'd1);
        send_beat(zc_pkg::OP_ENCODE, sb.fib_w[zc_pkg::CODE_BITS]);
        send_beat(zc_pkg::OP_ENCODE, sb.fib_w[zc_pkg::CODE_BITS] + 64'd1);
        send_beat(zc_pkg::OP_ENCODE, 64'h8000_0000_0000_0000);
        send_beat(zc_pkg::OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(zc_pkg::OP_DECODE, 64'd0);
        send_beat(zc_pkg::OP_DECODE, 64'd1);
        send_beat(zc_pkg::OP_DECODE, 64'd3);
        send_beat(zc_pkg::OP_DECODE, 64'h5555_5555_5555_5555);
        send_beat(zc_pkg::OP_DECODE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(zc_pkg::OP_DECODE, 64'h8000_0000_0000_0000);
        send_beat(zc_pkg::OP_DECODE, 64'hFFFF_FFFF_FFFF_FFFF);

        // Random beats under three idling mixes
        send_random(RAND_PER_PASS);
        send_idle_pct = 45;
        rcv_stall_pct = 6;
        send_random(RAND_PER_PASS);
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        // Hold off the receiver while requests keep coming
        hold_req = 1'b1;
        send_random(RAND_PER_PASS);

        @(posedge clk);
        req_valid <= 1'b0;

        // Drain, then allow for a stray late beat
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/zc_pkg.sv
rtl/zc_dpath.sv
rtl/zc_ctrl.sv
rtl/zeckendorf_codec_top.sv
tb/sv/zeckendorf_codec_top_tb.sv
